[sv/qxmm_pkg.sv]
// Shared constants and types for the quad X-frame motor mixer.
package qxmm_pkg;

  // Default number of fraction bits (Q2.14)
  localparam int FRAC_BITS_DEF = 14;

  // Fixed field widths
  localparam int CFG_W    = 15;
  localparam int THR_W    = 15;
  localparam int CMD_IN_W = 16;
  localparam int CMD_W    = 15;
  localparam int MIX_W    = 18;
  localparam int IDX_W    = 2;

  // Sum of three command magnitudes fits in this many bits
  localparam int SPREAD_W = 17;

  // Width of idle_thrust squared before the fraction shift
  localparam int IDLE_PROD_W = 2 * CFG_W;

  // Reset value of idle_thrust
  localparam logic [CFG_W-1:0] IDLE_RESET = 15'd1638;

  // Saturation limits of the mix_value field
  localparam int MIX_MAX_C = 131071;
  localparam int MIX_MIN_C = -131072;

  // Motor index codes
  localparam logic [IDX_W-1:0] MOTOR_0 = 2'd0;
  localparam logic [IDX_W-1:0] MOTOR_1 = 2'd1;
  localparam logic [IDX_W-1:0] MOTOR_2 = 2'd2;
  localparam logic [IDX_W-1:0] MOTOR_3 = 2'd3;

  // Kind of desaturation offset applied
  typedef enum logic [1:0] {
    OFF_NONE  = 2'd0,
    OFF_RAISE = 2'd1,
    OFF_LOWER = 2'd2
  } offset_kind_e;

endpackage

[sv/quad_x_motor_mixer_unit.sv]
// Quad X-frame motor mixer with desaturation and pipelined square root.
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+-----------------------------------
//  in       | input     | in_valid_i / in_stall_o  | motor_index, throttle, yaw, pitch, roll
//  out      | output    | out_valid_o / out_stall_i| motor_command, mix_value, offset_kind
//  cfg      | input     | cfg_we_i                 | cfg_wdata_i (idle_thrust)
//
// One request enters per cycle while the input is not stalled. The pipe holds
// five mix stages, then one restoring square-root step per stage for each of
// the RB root bits (15 at 14 fraction bits).
// Reset clears all valid bits and loads the default idle thrust.
// A stall on the output holds the last stage; earlier stages keep moving
// until the pipe is full, and only then is the input stalled.
module quad_x_motor_mixer_unit
  import qxmm_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration
  input  logic                       cfg_we_i,
  input  logic [CFG_W-1:0]           cfg_wdata_i,
  // Input channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [IDX_W-1:0]           motor_index_i,
  input  logic [THR_W-1:0]           throttle_i,
  input  logic signed [CMD_IN_W-1:0] yaw_i,
  input  logic signed [CMD_IN_W-1:0] pitch_i,
  input  logic signed [CMD_IN_W-1:0] roll_i,
  // Output channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [CMD_W-1:0]           motor_command_o,
  output logic signed [MIX_W-1:0]    mix_value_o,
  output logic [1:0]                 offset_kind_o
);

  // Clamped mix is at most 1.0 or idle squared
  localparam int CW = (FRAC_BITS + 1 > IDLE_PROD_W - FRAC_BITS) ?
                      FRAC_BITS + 1 : IDLE_PROD_W - FRAC_BITS;
  // Internal mix width with headroom for offsets and sums
  localparam int MW  = ((CW > SPREAD_W) ? CW : SPREAD_W) + 3;
  // Square root geometry
  localparam int RW0 = CW + FRAC_BITS;
  localparam int RB  = (RW0 + 1) / 2;
  localparam int RW  = 2 * RB;
  localparam int RMW = RB + 2;
  // Pipeline depth
  localparam int NS  = 5 + RB;

  localparam logic signed [MW-1:0] ONE_X     = MW'(longint'(1) << FRAC_BITS);
  localparam logic signed [MW-1:0] FIELD_MAX = MW'(MIX_MAX_C);
  localparam logic signed [MW-1:0] FIELD_MIN = MW'(MIX_MIN_C);

  // ---------------------------------------------------------------
  // Configuration register
  logic [CFG_W-1:0] idle_thrust_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_thrust_q <= IDLE_RESET;
    end else if (cfg_we_i) begin
      idle_thrust_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------
  // Valid bits and stall flow
  logic [NS-1:0] v_q, v_d;
  logic [NS-1:0] rdy;

  // A stage may load when the output is not stalled or any stage at or after it holds a bubble
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = !out_stall_i || !(&v_q[NS-1:k]);
  end

  always_comb begin
    v_d = v_q;
    if (rdy[0]) begin
      v_d[0] = in_valid_i;
    end
    for (int k = 1; k < NS; k++) begin
      if (rdy[k]) begin
        v_d[k] = v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = v_q[NS-1];

  // ---------------------------------------------------------------
  // Stage 0: capture the request
  logic [IDX_W-1:0]           s0_idx_q;
  logic [THR_W-1:0]           s0_thr_q;
  logic signed [CMD_IN_W-1:0] s0_yaw_q, s0_pitch_q, s0_roll_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s0_idx_q   <= motor_index_i;
      s0_thr_q   <= throttle_i;
      s0_yaw_q   <= yaw_i;
      s0_pitch_q <= pitch_i;
      s0_roll_q  <= roll_i;
    end
  end

  // ---------------------------------------------------------------
  // Stage 1: spread, signed mix by motor, idle squared
  logic signed [MW-1:0]    yaw_x, pitch_x, roll_x, thr_x;
  logic signed [MW-1:0]    spread_d, raw_d, idle2_d;
  logic [IDLE_PROD_W-1:0]  idle_prod;

  assign yaw_x     = MW'(s0_yaw_q);
  assign pitch_x   = MW'(s0_pitch_q);
  assign roll_x    = MW'(s0_roll_q);
  assign thr_x     = signed'(MW'(s0_thr_q));
  assign idle_prod = IDLE_PROD_W'(idle_thrust_q) * IDLE_PROD_W'(idle_thrust_q);
  assign idle2_d   = signed'(MW'(idle_prod >> FRAC_BITS));

  always_comb begin
    spread_d = ((yaw_x < 0) ? -yaw_x : yaw_x)
             + ((pitch_x < 0) ? -pitch_x : pitch_x)
             + ((roll_x < 0) ? -roll_x : roll_x);
    unique case (s0_idx_q)
      MOTOR_0: raw_d = thr_x - yaw_x - pitch_x - roll_x;
      MOTOR_1: raw_d = thr_x + yaw_x + pitch_x - roll_x;
      MOTOR_2: raw_d = thr_x + yaw_x - pitch_x + roll_x;
      MOTOR_3: raw_d = thr_x - yaw_x + pitch_x + roll_x;
      default: raw_d = thr_x - yaw_x + pitch_x + roll_x;
    endcase
  end

  logic signed [MW-1:0] s1_thr_q, s1_spread_q, s1_raw_q, s1_idle2_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      s1_thr_q    <= thr_x;
      s1_spread_q <= spread_d;
      s1_raw_q    <= raw_d;
      s1_idle2_q  <= idle2_d;
    end
  end

  // ---------------------------------------------------------------
  // Stage 2: desaturation offset; lowering to full wins
  logic signed [MW-1:0] lo, hi, off_d;
  offset_kind_e         kind_d;

  assign lo = s1_thr_q - s1_spread_q;
  assign hi = s1_thr_q + s1_spread_q;

  always_comb begin
    if (hi > ONE_X) begin
      off_d  = ONE_X - hi;
      kind_d = OFF_LOWER;
    end else if (lo < s1_idle2_q) begin
      off_d  = s1_idle2_q - lo;
      kind_d = OFF_RAISE;
    end else begin
      off_d  = '0;
      kind_d = OFF_NONE;
    end
  end

  logic signed [MW-1:0] s2_raw_q, s2_off_q, s2_idle2_q;
  offset_kind_e         s2_kind_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      s2_raw_q   <= s1_raw_q;
      s2_off_q   <= off_d;
      s2_idle2_q <= s1_idle2_q;
      s2_kind_q  <= kind_d;
    end
  end

  // ---------------------------------------------------------------
  // Stage 3: apply the offset
  logic signed [MW-1:0] s3_mix_q, s3_idle2_q;
  offset_kind_e         s3_kind_q;

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      s3_mix_q   <= s2_raw_q + s2_off_q;
      s3_idle2_q <= s2_idle2_q;
      s3_kind_q  <= s2_kind_q;
    end
  end

  // ---------------------------------------------------------------
  // Stage 4: clamp to [idle squared, 1.0], saturate the field, form radicand
  logic signed [MW-1:0] clamp_c;
  logic [MIX_W-1:0]     field_d;
  logic [RW-1:0]        rad_d;

  always_comb begin
    clamp_c = (s3_mix_q < ONE_X) ? s3_mix_q : ONE_X;
    if (clamp_c < s3_idle2_q) begin
      clamp_c = s3_idle2_q;
    end
    if (s3_mix_q > FIELD_MAX) begin
      field_d = FIELD_MAX[MIX_W-1:0];
    end else if (s3_mix_q < FIELD_MIN) begin
      field_d = FIELD_MIN[MIX_W-1:0];
    end else begin
      field_d = s3_mix_q[MIX_W-1:0];
    end
    rad_d = RW'(clamp_c[CW-1:0]) << FRAC_BITS;
  end

  // Square root pipe: entry 0 is stage 4, entry j+1 is stage 5+j
  logic [RW-1:0]    sq_rad_q   [RB+1];
  logic [RMW-1:0]   sq_rem_q   [RB+1];
  logic [RB-1:0]    sq_root_q  [RB+1];
  logic [MIX_W-1:0] sq_field_q [RB+1];
  offset_kind_e     sq_kind_q  [RB+1];

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      sq_rad_q[0]   <= rad_d;
      sq_rem_q[0]   <= '0;
      sq_root_q[0]  <= '0;
      sq_field_q[0] <= field_d;
      sq_kind_q[0]  <= s3_kind_q;
    end
  end

  // ---------------------------------------------------------------
  // Stages 5 and up: one restoring root bit per stage
  for (genvar j = 0; j < RB; j++) begin : g_sqrt
    logic [RMW-1:0] rem_pre, trial, rem_nxt;
    logic           take;

    always_comb begin
      rem_pre = {sq_rem_q[j][RMW-3:0], sq_rad_q[j][RW-1 -: 2]};
      trial   = {sq_root_q[j], 2'b01};
      take    = (rem_pre >= trial);
      rem_nxt = take ? (rem_pre - trial) : rem_pre;
    end

    always_ff @(posedge clk_i) begin
      if (rdy[5+j]) begin
        sq_rad_q[j+1]   <= sq_rad_q[j] << 2;
        sq_rem_q[j+1]   <= rem_nxt;
        sq_root_q[j+1]  <= {sq_root_q[j][RB-2:0], take};
        sq_field_q[j+1] <= sq_field_q[j];
        sq_kind_q[j+1]  <= sq_kind_q[j];
      end
    end
  end

  // ---------------------------------------------------------------
  // Drive the result
  assign motor_command_o = sq_root_q[RB][CMD_W-1:0];
  assign mix_value_o     = signed'(sq_field_q[RB]);
  assign offset_kind_o   = sq_kind_q[RB];

  // ---------------------------------------------------------------
  // Checks
  a_stall_only_when_full : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&v_q)
  ) else $error("input stalled while the pipe holds a bubble");

  a_no_offset_mix_nonneg : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && offset_kind_o == OFF_NONE) |-> !mix_value_o[MIX_W-1]
  ) else $error("mix below zero without a raising offset");

  a_command_at_most_one : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && int'(idle_thrust_q) <= (1 << FRAC_BITS))
      |-> int'(motor_command_o) <= (1 << FRAC_BITS)
  ) else $error("motor command above full scale");

endmodule
